// ----- rtl/core/vactrol_slew_envelope_macros.svh -----
// Assertion macros for the checker file.
`ifndef VACTROL_SLEW_ENVELOPE_MACROS_SVH
`define VACTROL_SLEW_ENVELOPE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vse: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define VSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vse: next-cycle check failed");

`endif

// ----- rtl/core/vse_pkg.sv -----
package vse_pkg;

  // Field widths
  localparam int LVL_W    = 17;   // unsigned Q1.16
  localparam int RATE_W   = 24;   // unsigned Q0.24
  localparam int SLEW_W   = 22;   // capped slew, below 2^22
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int STEP_W   = 3;

  // Shared multiplier
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Constants
  localparam logic [LVL_W-1:0]  UNITY      = 17'd65536;
  localparam logic [SLEW_W-1:0] SLEW_CAP   = 22'd3355443;   // 0.2 in Q0.24
  localparam logic [RATE_W-1:0] RISE_RST   = 24'd582542;
  localparam logic [RATE_W-1:0] FALL_RST   = 24'd65303;
  localparam logic [LVL_W-1:0]  FLOOR_RST  = 17'd82;

  // Request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 2'd3;

  typedef enum logic [1:0] {
    MODE_SUSTAIN,
    MODE_CYCLE,
    MODE_TRANSIENT,
    MODE_FROZEN
  } vse_mode_t;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_TERM,
    MUL_STEP
  } vse_mul_t;

  // Branch conditions of the sequencer
  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_IN,
    C_SKIP,
    C_OUT_BUSY,
    C_JUMP
  } vse_cond_t;

  // One control word
  typedef struct packed {
    logic              idle;
    logic              dec_en;
    vse_mul_t          mul_op;
    logic              lvl_upd;
    logic              out_load;
    vse_cond_t         cond;
    logic [STEP_W-1:0] jump;
  } vse_uword_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic skip;
    logic out_busy;
  } vse_stat_t;

  // Program steps
  localparam logic [STEP_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] ST_DEC  = 3'd1;
  localparam logic [STEP_W-1:0] ST_TERM = 3'd2;
  localparam logic [STEP_W-1:0] ST_STEP = 3'd3;
  localparam logic [STEP_W-1:0] ST_UPD  = 3'd4;
  localparam logic [STEP_W-1:0] ST_OUT  = 3'd5;

  // Microcode program
  function automatic vse_uword_t vse_ucode(input logic [STEP_W-1:0] step);
    vse_uword_t w;
    w = '0;
    w.mul_op = MUL_NONE;
    w.cond = C_NEXT;
    case (step)
      ST_IDLE: begin
        w.idle = 1'b1;
        w.cond = C_WAIT_IN;
      end
      ST_DEC: begin
        w.dec_en = 1'b1;
        w.mul_op = MUL_SQ;
        w.cond = C_SKIP;
        w.jump = ST_OUT;
      end
      ST_TERM: w.mul_op = MUL_TERM;
      ST_STEP: w.mul_op = MUL_STEP;
      ST_UPD:  w.lvl_upd = 1'b1;
      ST_OUT: begin
        w.out_load = 1'b1;
        w.cond = C_OUT_BUSY;
        w.jump = ST_IDLE;
      end
      default: begin
        w.cond = C_JUMP;
        w.jump = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/vse_sequencer.sv -----
module vse_sequencer
  import vse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  vse_stat_t  stat,
  output vse_uword_t ctrl
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [STEP_W-1:0] step_inc;

  // Control word lookup
  assign ctrl     = vse_ucode(step_r);
  assign step_inc = step_r + STEP_W'(1);

  // Branch resolution
  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:     step_nxt = step_inc;
      C_WAIT_IN:  step_nxt = in_acc ? step_inc : step_r;
      C_SKIP:     step_nxt = stat.skip ? ctrl.jump : step_inc;
      C_OUT_BUSY: step_nxt = stat.out_busy ? step_r : ctrl.jump;
      C_JUMP:     step_nxt = ctrl.jump;
      default:    step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- rtl/core/vse_datapath.sv -----
module vse_datapath
  import vse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  vse_uword_t           ctrl,
  output vse_stat_t            stat,
  // input word capture
  input  logic                 in_acc,
  input  logic                 in_req_type,
  input  logic [LVL_W-1:0]     in_dest_value,
  // register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  // result register
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [LVL_W-1:0]     out_level_out
);

  // Registers and state
  vse_mode_t          mode_r;
  logic [RATE_W-1:0]  rise_r, fall_r;
  logic [LVL_W-1:0]   floor_r;
  logic [LVL_W-1:0]   level_r, target_r, vel_r;
  logic               out_valid_r;
  logic [LVL_W-1:0]   out_level_r;

  // Per-item working registers
  logic               req_r;
  logic [LVL_W-1:0]   dest_r;
  logic [RATE_W-1:0]  rate_r;
  logic               neg_r;
  logic [LVL_W-1:0]   mag_r;
  logic [LVL_W-1:0]   sq_r;
  logic [SLEW_W-1:0]  slew_r;
  logic [LVL_W-1:0]   stepmag_r;

  // Decision logic
  logic [LVL_W-1:0]   dsat;
  logic               diff_pos;
  logic [LVL_W-1:0]   mag;
  logic               close;
  logic [LVL_W-1:0]   target_nxt, vel_nxt;
  logic [RATE_W-1:0]  rate_nxt;
  logic               hold;
  logic               skip;

  always_comb begin
    dsat       = (dest_r > UNITY) ? UNITY : dest_r;
    diff_pos   = target_r > level_r;
    mag        = diff_pos ? (target_r - level_r) : (level_r - target_r);
    close      = mag < floor_r;
    target_nxt = target_r;
    vel_nxt    = vel_r;
    rate_nxt   = fall_r;
    hold       = 1'b0;
    skip       = 1'b0;
    if (req_r == REQ_SET) begin
      target_nxt = dsat;
      if (dsat > floor_r) begin
        vel_nxt = dsat;
      end
      skip = 1'b1;
    end else if (mode_r == MODE_FROZEN) begin
      skip = 1'b1;
    end else begin
      if (diff_pos) begin
        if (close) begin
          if (mode_r == MODE_SUSTAIN) begin
            hold = 1'b1;
          end else begin
            target_nxt = '0;
          end
        end else begin
          rate_nxt = rise_r;
        end
      end else if (close) begin
        case (mode_r)
          MODE_SUSTAIN: hold = 1'b1;
          MODE_CYCLE: begin
            if (target_r == vel_r) begin
              target_nxt = '0;
            end else begin
              target_nxt = vel_r;
              rate_nxt   = rise_r;
            end
          end
          default: begin
            // transient: decay to zero, then rest there
            if (target_r == '0) begin
              hold = 1'b1;
            end else begin
              target_nxt = '0;
            end
          end
        endcase
      end
      skip = hold;
    end
  end

  // Shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    case (ctrl.mul_op)
      MUL_SQ: begin
        mul_a = MUL_A_W'(level_r);
        mul_b = level_r;
      end
      MUL_TERM: begin
        mul_a = rate_r;
        mul_b = sq_r;
      end
      MUL_STEP: begin
        mul_a = MUL_A_W'(slew_r);
        mul_b = mag_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Rounding and saturation after the product
  logic [PROD_W-1:0]  sq_sum, term_sum, step_sum;
  logic [26:0]        slew_sum;
  logic [SLEW_W-1:0]  slew_sat;

  assign sq_sum   = prod + PROD_W'(32768);
  assign term_sum = prod + PROD_W'(16384);
  assign step_sum = prod + PROD_W'(8388608);
  assign slew_sum = 27'(rate_r) + 27'(term_sum[PROD_W-1:15]);
  assign slew_sat = (slew_sum > 27'(SLEW_CAP)) ? SLEW_CAP : slew_sum[SLEW_W-1:0];

  // Level update with clamp to [0, 1.0]
  logic [LVL_W:0]     lvl_up;
  logic [LVL_W-1:0]   level_nxt;

  assign lvl_up = {1'b0, level_r} + {1'b0, stepmag_r};

  always_comb begin
    if (neg_r) begin
      level_nxt = (stepmag_r > level_r) ? '0 : (level_r - stepmag_r);
    end else begin
      level_nxt = (lvl_up > {1'b0, UNITY}) ? UNITY : lvl_up[LVL_W-1:0];
    end
  end

  logic out_busy;
  assign out_busy = out_valid_r && out_stall;

  // Control state, registers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SUSTAIN;
      rise_r      <= RISE_RST;
      fall_r      <= FALL_RST;
      floor_r     <= FLOOR_RST;
      level_r     <= '0;
      target_r    <= '0;
      vel_r       <= UNITY;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: begin
            mode_r <= vse_mode_t'(cfg_wdata[1:0]);
            if (vse_mode_t'(cfg_wdata[1:0]) != MODE_SUSTAIN) begin
              target_r <= '0;
            end
          end
          REG_RISE:  rise_r  <= cfg_wdata[RATE_W-1:0];
          REG_FALL:  fall_r  <= cfg_wdata[RATE_W-1:0];
          REG_FLOOR: floor_r <= cfg_wdata[LVL_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.dec_en) begin
        target_r <= target_nxt;
        vel_r    <= vel_nxt;
        if (hold) begin
          level_r <= target_r;
        end
      end
      if (ctrl.lvl_upd) begin
        level_r <= level_nxt;
      end
      if (ctrl.out_load && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_req_type;
      dest_r <= in_dest_value;
    end
    if (ctrl.dec_en) begin
      rate_r <= rate_nxt;
      neg_r  <= !diff_pos;
      mag_r  <= mag;
    end
    case (ctrl.mul_op)
      MUL_SQ:   sq_r      <= sq_sum[32:16];
      MUL_TERM: slew_r    <= slew_sat;
      MUL_STEP: stepmag_r <= step_sum[PROD_W-1:24];
      default: ;
    endcase
    if (ctrl.out_load && !out_busy) begin
      out_level_r <= level_r;
    end
  end

  assign stat.skip     = skip;
  assign stat.out_busy = out_busy;
  assign out_valid     = out_valid_r;
  assign out_level_out = out_level_r;

endmodule

// ----- rtl/core/vactrol_slew_envelope.sv -----
// Channel | Direction | Handshake            | Word
// in_     | input     | in_valid / in_stall  | in_req_type, in_dest_value
// out_    | output    | out_valid / out_stall| out_level_out
// cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One word at a time. The squared level, the scaled rate and the step of a tick
// all pass through one shared 24x17 multiplier, one product per microcode step,
// in the decode, term and step steps, before the level update and output steps.
// A set-destination word, a hold near the target, or mode three goes from the
// decode step straight to the output step. The next word is taken while the
// result waits in the output register.
// rst_n is synchronous; sequencer, register and envelope state flops return to
// their defaults. A stalled result holds the sequencer at its output step.
module vactrol_slew_envelope
  import vse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [LVL_W-1:0]     in_dest_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LVL_W-1:0]     out_level_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  vse_uword_t ctrl;
  vse_stat_t  stat;
  logic       in_acc;

  // Input is taken only at the idle step
  assign in_stall  = !ctrl.idle;
  assign in_acc    = in_valid && ctrl.idle;
  assign cfg_ready = 1'b1;

  vse_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_acc (in_acc),
    .stat   (stat),
    .ctrl   (ctrl)
  );

  vse_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .in_acc        (in_acc),
    .in_req_type   (in_req_type),
    .in_dest_value (in_dest_value),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_level_out (out_level_out)
  );

endmodule

// ----- rtl/core/vse_checker.sv -----
`include "vactrol_slew_envelope_macros.svh"

module vse_checker
  import vse_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [LVL_W-1:0] out_level_out
);

  // Level never leaves [0, 1.0]
  `VSE_ASSERT_NOW(a_level_range, out_valid, out_level_out <= UNITY)

  // A waiting result stays offered
  `VSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A waiting result keeps its word
  `VSE_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_level_out))

  // After an accept the input stays stalled through the decode step and the step after it
  `VSE_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall ##1 in_stall)

endmodule

bind vactrol_slew_envelope vse_checker u_vse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_level_out (out_level_out)
);

// ----- tb/tb_top.sv -----
module tb_top
  import vse_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;   // cycles with no word moving on any channel
  localparam int SETTLE_CYC  = 8;
  localparam int HOLDOFF_CYC = 300;

  typedef struct packed {
    logic             req;
    logic [LVL_W-1:0] dest;
  } env_word_t;

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_req_type   = REQ_TICK;
  logic [LVL_W-1:0]     in_dest_value = '0;
  logic                 out_stall     = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_MODE;
  logic [CFG_DAT_W-1:0] cfg_wdata     = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [LVL_W-1:0]     out_level_out;
  logic                 cfg_ready;

  vactrol_slew_envelope dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_dest_value (in_dest_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_level_out (out_level_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Predicted envelope state and register copy
  vse_mode_t         r_mode  = MODE_SUSTAIN;
  logic [RATE_W-1:0] r_rise  = RISE_RST;
  logic [RATE_W-1:0] r_fall  = FALL_RST;
  logic [LVL_W-1:0]  r_floor = FLOOR_RST;
  logic [LVL_W-1:0]  env_lvl = '0;
  logic [LVL_W-1:0]  env_tgt = '0;
  logic [LVL_W-1:0]  env_vel = UNITY;

  env_word_t        word_q[$];     // words waiting for the driver
  logic [LVL_W-1:0] level_q[$];    // predicted levels, oldest first

  int  n_queued    = 0;
  int  n_in        = 0;
  int  n_out       = 0;
  int  n_fail      = 0;
  int  n_setups    = 0;
  int  quiet       = 0;
  int  in_idle_pct = 38;
  int  out_idle_pct = 38;
  bit  press_on    = 1'b0;
  bit  press_done  = 1'b0;
  int  hold_left   = 0;
  logic in_took    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Register write as the block sees it
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] val);
    case (idx)
      REG_MODE: begin
        r_mode = vse_mode_t'(val[1:0]);
        if (r_mode != MODE_SUSTAIN) env_tgt = '0;
      end
      REG_RISE:  r_rise  = val[RATE_W-1:0];
      REG_FALL:  r_fall  = val[RATE_W-1:0];
      REG_FLOOR: r_floor = val[LVL_W-1:0];
      default: ;
    endcase
  endfunction

  // One word through the envelope; returns the level it produces
  function automatic logic [LVL_W-1:0] envelope_advance(input logic req,
                                                        input logic [LVL_W-1:0] dv);
    logic [LVL_W-1:0] d;
    logic             hold;
    longint           lv, tv, flr, rt, diff, sq, term, slew, mag, stepmag, nxt;
    d    = dv;
    hold = 1'b0;
    rt   = r_fall;
    if (req == REQ_SET) begin
      if (d > UNITY) d = UNITY;
      env_tgt = d;
      if (d > r_floor) env_vel = d;
    end else if (r_mode != MODE_FROZEN) begin
      lv   = env_lvl;
      tv   = env_tgt;
      flr  = r_floor;
      diff = tv - lv;
      // end cases near the target, decided on the old target
      if (diff > 0) begin
        if (diff < flr) begin
          if (r_mode == MODE_SUSTAIN) hold = 1'b1;
          else env_tgt = '0;
        end else begin
          rt = r_rise;
        end
      end else if (diff > -flr) begin
        case (r_mode)
          MODE_SUSTAIN: hold = 1'b1;
          MODE_CYCLE: begin
            if (env_tgt == env_vel) begin
              env_tgt = '0;
            end else begin
              env_tgt = env_vel;
              rt = r_rise;
            end
          end
          default: begin
            if (env_tgt == '0) hold = 1'b1;
            else env_tgt = '0;
          end
        endcase
      end
      if (hold) begin
        env_lvl = env_tgt;
      end else begin
        // rate * (1 + 2*level^2), capped at 0.2, times diff, rounded away from 0
        sq   = (lv * lv + 32768) >>> 16;
        term = (rt * sq + 16384) >>> 15;
        slew = rt + term;
        if (slew > longint'(SLEW_CAP)) slew = SLEW_CAP;
        mag     = (diff < 0) ? -diff : diff;
        stepmag = (slew * mag + 64'd8388608) >>> 24;
        nxt     = (diff < 0) ? lv - stepmag : lv + stepmag;
        if (nxt < 0) nxt = 0;
        if (nxt > longint'(UNITY)) nxt = UNITY;
        env_lvl = nxt[LVL_W-1:0];
      end
    end
    return env_lvl;
  endfunction

  // Input driver: next word after an accept, random idle cycles between words
  always @(negedge clk) begin
    env_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (word_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        w = word_q.pop_front();
        in_valid      <= 1'b1;
        in_req_type   <= w.req;
        in_dest_value <= w.dest;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: random, plus one long hold-off while words keep coming
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (press_on && !press_done) begin
      press_done = 1'b1;
      hold_left  = HOLDOFF_CYC;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Monitor: check results, predict accepted words, watchdog
  always @(posedge clk) begin
    logic [LVL_W-1:0] want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        n_out++;
        if (level_q.size() == 0) begin
          $error("level_out: no word expected, actual %0d", out_level_out);
          n_fail++;
        end else begin
          want = level_q.pop_front();
          if (out_level_out !== want) begin
            $error("level_out mismatch: expected %0d, actual %0d", want, out_level_out);
            n_fail++;
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        level_q.push_back(envelope_advance(in_req_type, in_dest_value));
        n_in++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_word(input logic req, input logic [LVL_W-1:0] dv);
    word_q.push_back('{req: req, dest: dv});
    n_queued++;
  endtask

  // Wait until every word has been taken and answered, then let the block go idle
  task automatic settle();
    @(negedge clk);
    while (n_in != n_queued || level_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Returns at the rising edge that took the write; cfg_valid stays up
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input vse_mode_t m, input logic [RATE_W-1:0] rr,
                          input logic [RATE_W-1:0] fr, input logic [LVL_W-1:0] fl);
    write_reg(REG_RISE, 24'(rr));
    write_reg(REG_FALL, 24'(fr));
    write_reg(REG_FLOOR, 24'(fl));
    write_reg(REG_MODE, 24'(m));
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_setups++;
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return RATE_W'($urandom);
      default: return RATE_W'($urandom_range(3355443, 300000));
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] pick_floor();
    case ($urandom_range(7))
      0:       return '0;
      1:       return UNITY;
      2:       return LVL_W'($urandom_range(131071, 65537));
      default: return LVL_W'($urandom_range(4000, 1));
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] pick_dest();
    case ($urandom_range(5))
      0:       return '0;
      1:       return UNITY;
      2:       return LVL_W'($urandom_range(131071, 65537));
      3:       return LVL_W'($urandom_range(200));
      default: return LVL_W'($urandom_range(65536));
    endcase
  endfunction

  // Mostly a new destination followed by a run of ticks, some loose words
  task automatic queue_random(input int cnt);
    int k;
    k = 0;
    while (k < cnt) begin
      if ($urandom_range(99) < 80) begin
        push_word(REQ_SET, pick_dest());
        k++;
        repeat ($urandom_range(40, 3)) begin
          if (k < cnt) begin
            push_word(REQ_TICK, LVL_W'($urandom));
            k++;
          end
        end
      end else begin
        push_word(1'($urandom_range(1)), LVL_W'($urandom));
        k++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers, sustain: saturation, floor boundary for velocity
    push_word(REQ_SET, UNITY);
    push_word(REQ_TICK, 17'h1FFFF);
    push_word(REQ_TICK, '0);
    push_word(REQ_SET, 17'h1FFFF);
    push_word(REQ_TICK, '0);
    push_word(REQ_SET, '0);
    push_word(REQ_TICK, 17'h0AAAA);
    push_word(REQ_SET, FLOOR_RST);
    push_word(REQ_SET, FLOOR_RST + 17'd1);
    push_word(REQ_TICK, 17'h15555);
    settle();

    // Wide floor: sustain snaps to the target both ways
    set_regs(MODE_SUSTAIN, '1, '1, UNITY);
    push_word(REQ_SET, 17'd30000);
    push_word(REQ_TICK, '0);
    push_word(REQ_SET, 17'd10000);
    push_word(REQ_TICK, '0);
    settle();

    // Cycle: target swaps between velocity and zero
    set_regs(MODE_CYCLE, '1, '1, UNITY);
    push_word(REQ_SET, 17'd50000);
    repeat (4) push_word(REQ_TICK, '0);
    settle();

    // Transient: decay then hold at zero
    set_regs(MODE_TRANSIENT, '1, '1, UNITY);
    push_word(REQ_SET, 17'd40000);
    repeat (3) push_word(REQ_TICK, '0);
    settle();

    // Mode three: ticks leave the level alone
    set_regs(MODE_FROZEN, '1, '1, UNITY);
    push_word(REQ_SET, 17'd20000);
    push_word(REQ_TICK, '0);
    settle();

    // Random phases; first few pinned to register extremes
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_regs(MODE_SUSTAIN, '1, '1, 17'd82);
        1: set_regs(MODE_CYCLE, 24'd2000000, 24'd3000000, 17'd300);
        2: set_regs(MODE_TRANSIENT, '1, 24'd1500000, 17'd1000);
        3: set_regs(MODE_FROZEN, '0, '0, '0);
        4: set_regs(MODE_SUSTAIN, '0, '0, UNITY);
        default: set_regs(vse_mode_t'($urandom_range(3)), pick_rate(), pick_rate(),
                          pick_floor());
      endcase
      if (ph == 2) press_on = 1'b1;
      if (ph == 5) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      queue_random(90);
      settle();
      in_idle_pct  = 38;
      out_idle_pct = 38;
    end

    repeat (20) @(negedge clk);
    if (level_q.size() != 0) begin
      $error("level_out: %0d expected words never arrived", level_q.size());
      n_fail++;
    end
    $display("Run covered %0d words in and %0d levels out over %0d register setups,",
             n_in, n_out, n_setups);
    $display("all four modes, rate and floor extremes, and a long result hold-off.");
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/vse_pkg.sv
rtl/core/vse_sequencer.sv
rtl/core/vse_datapath.sv
rtl/core/vactrol_slew_envelope.sv
rtl/core/vse_checker.sv
tb/tb_top.sv
